// ----- design/b32d_pkg.sv -----
// ----------------------------------------------------------------------------
// Base32 stream decoder package
// Types, constants and helper functions shared by the decoder's front end,
// job queue and byte emitter.
// ----------------------------------------------------------------------------
package b32d_pkg;

  // Symbols held in one full group, and the group's packed width.
  localparam int unsigned GROUP_SYMBOLS = 8;
  localparam int unsigned SYMBOL_WIDTH  = 5;
  localparam int unsigned GROUP_WIDTH   = GROUP_SYMBOLS * SYMBOL_WIDTH;

  // Depth of the queue between the front end and the byte emitter.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_WIDTH  = $clog2(QUEUE_DEPTH);

  // ASCII codes that bound the character classes.
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CHAR_TWO     = 8'h32;
  localparam logic [7:0] CHAR_SEVEN   = 8'h37;
  localparam logic [7:0] CHAR_ONE     = 8'h31;
  localparam logic [7:0] CHAR_PAD     = 8'h3d;

  // Offset that maps '2'..'7' onto 26..31.
  localparam logic [7:0] DIGIT_OFFSET = 8'd24;
  // The character '1' is read as 'I'.
  localparam logic [4:0] VALUE_OF_ONE = 5'd8;

  // Class of one input character.
  typedef enum logic [1:0] {
    SYM_DATA,
    SYM_PAD,
    SYM_BAD
  } sym_kind_t;

  typedef struct packed {
    sym_kind_t       kind;
    logic [4:0]      value;
  } sym_t;

  // One unit of work for the byte emitter: a packed group, its byte count
  // (1 to 5) and an error mark.
  typedef struct packed {
    logic [GROUP_WIDTH-1:0] bits;
    logic [2:0]             nbytes;
    logic                   err;
  } job_t;

  // Decodes one ASCII byte into its symbol class and value.
  function automatic sym_t classify(input logic [7:0] c);
    sym_t       s;
    logic [7:0] diff;
    s.kind  = SYM_BAD;
    s.value = '0;
    diff    = '0;
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      diff    = c - CHAR_LOWER_A;
      s.kind  = SYM_DATA;
      s.value = diff[4:0];
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      diff    = c - CHAR_UPPER_A;
      s.kind  = SYM_DATA;
      s.value = diff[4:0];
    end else if (c >= CHAR_TWO && c <= CHAR_SEVEN) begin
      diff    = c - DIGIT_OFFSET;
      s.kind  = SYM_DATA;
      s.value = diff[4:0];
    end else if (c == CHAR_ONE) begin
      s.kind  = SYM_DATA;
      s.value = VALUE_OF_ONE;
    end else if (c == CHAR_PAD) begin
      s.kind  = SYM_PAD;
    end
    return s;
  endfunction

  // Bytes given by a group, indexed by pad position or by short count.
  function automatic logic [2:0] byte_count(input logic [2:0] idx);
    logic [2:0] n;
    unique case (idx)
      3'd0:    n = 3'd5;
      3'd1:    n = 3'd1;
      3'd2:    n = 3'd1;
      3'd3:    n = 3'd2;
      3'd4:    n = 3'd2;
      3'd5:    n = 3'd3;
      3'd6:    n = 3'd4;
      3'd7:    n = 3'd4;
      default: n = 3'd5;
    endcase
    return n;
  endfunction

endpackage

// ----- design/b32d_front.sv -----
// ----------------------------------------------------------------------------
// Base32 decoder front end
// Accepts characters, classifies them, gathers groups of eight symbols and
// hands each closed group, short final group or error on as one job.
// ----------------------------------------------------------------------------
module b32d_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [7:0]     symbol,
  input  logic           end_of_stream,
  output logic           push,
  output b32d_pkg::job_t job
);

  logic [4:0] group [b32d_pkg::GROUP_SYMBOLS];
  logic [2:0] count;
  logic [2:0] pad_pos;
  logic       discarding;

  b32d_pkg::sym_t sym;
  logic [4:0]     sym_value;
  logic [2:0]     pad_pos_next;
  logic           close_full;
  logic           close_short;
  logic [b32d_pkg::GROUP_WIDTH-1:0] word;

  // Classify the character and work out the pad position it leaves.
  always_comb begin
    sym          = b32d_pkg::classify(symbol);
    sym_value    = (sym.kind == b32d_pkg::SYM_DATA) ? sym.value : 5'd0;
    pad_pos_next = pad_pos;
    if (sym.kind == b32d_pkg::SYM_PAD && pad_pos == 3'd0) begin
      pad_pos_next = count;
    end
  end

  // Pack the open group with the current symbol in its slot; later slots
  // are still clear.
  always_comb begin
    for (int i = 0; i < b32d_pkg::GROUP_SYMBOLS; i++) begin
      word[b32d_pkg::GROUP_WIDTH-1-i*b32d_pkg::SYMBOL_WIDTH -: b32d_pkg::SYMBOL_WIDTH] =
        (count == i[2:0]) ? sym_value : group[i];
    end
  end

  // Decide whether this beat closes a group or reports an error.
  always_comb begin
    close_full  = (count == 3'd7);
    close_short = !close_full && end_of_stream;
    push        = 1'b0;
    job.bits    = word;
    job.nbytes  = 3'd0;
    job.err     = 1'b0;
    if (accept && !discarding) begin
      if (sym.kind == b32d_pkg::SYM_BAD) begin
        push       = 1'b1;
        job.bits   = '0;
        job.nbytes = 3'd1;
        job.err    = 1'b1;
      end else if (close_full) begin
        push       = 1'b1;
        job.nbytes = b32d_pkg::byte_count(pad_pos_next);
      end else if (close_short) begin
        push       = 1'b1;
        job.nbytes = b32d_pkg::byte_count(count + 3'd1);
      end
    end
  end

  // Group store and stream state.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < b32d_pkg::GROUP_SYMBOLS; i++) begin
        group[i] <= '0;
      end
      count      <= '0;
      pad_pos    <= '0;
      discarding <= 1'b0;
    end else if (accept) begin
      if (discarding) begin
        if (end_of_stream) begin
          discarding <= 1'b0;
        end
      end else if (sym.kind == b32d_pkg::SYM_BAD || close_full || close_short) begin
        for (int i = 0; i < b32d_pkg::GROUP_SYMBOLS; i++) begin
          group[i] <= '0;
        end
        count      <= '0;
        pad_pos    <= '0;
        discarding <= (sym.kind == b32d_pkg::SYM_BAD) && !end_of_stream;
      end else begin
        group[count] <= sym_value;
        count        <= count + 3'd1;
        pad_pos      <= pad_pos_next;
      end
    end
  end

endmodule

// ----- design/b32d_queue.sv -----
// ----------------------------------------------------------------------------
// Base32 decoder job queue
// A small first-in first-out store of jobs that lets the front end and the
// byte emitter stall independently.
// ----------------------------------------------------------------------------
module b32d_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  b32d_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output b32d_pkg::job_t head_job
);

  b32d_pkg::job_t store [b32d_pkg::QUEUE_DEPTH];
  logic [b32d_pkg::QPTR_WIDTH-1:0] wr_ptr;
  logic [b32d_pkg::QPTR_WIDTH-1:0] rd_ptr;
  logic [b32d_pkg::QPTR_WIDTH:0]   fill;

  localparam logic [b32d_pkg::QPTR_WIDTH:0] FULL_LEVEL =
    (b32d_pkg::QPTR_WIDTH + 1)'(b32d_pkg::QUEUE_DEPTH);

  assign full       = (fill == FULL_LEVEL);
  assign head_valid = (fill != '0);
  assign head_job   = store[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- design/b32d_back.sv -----
// ----------------------------------------------------------------------------
// Base32 decoder byte emitter
// Takes jobs from the queue and sends their bytes one beat at a time through
// an output register.
// ----------------------------------------------------------------------------
module b32d_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  b32d_pkg::job_t head_job,
  output logic           pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata,
  output logic           m_tlast,
  output logic [0:0]     m_tuser
);

  logic [2:0] byte_idx;
  logic       load;
  logic       last_byte;
  logic [7:0] byte_sel;

  // Pick the current byte of the head job.
  always_comb begin
    case (byte_idx)
      3'd0:    byte_sel = head_job.bits[39:32];
      3'd1:    byte_sel = head_job.bits[31:24];
      3'd2:    byte_sel = head_job.bits[23:16];
      3'd3:    byte_sel = head_job.bits[15:8];
      3'd4:    byte_sel = head_job.bits[7:0];
      default: byte_sel = 8'd0;
    endcase
  end

  assign load      = head_valid && (!m_tvalid || m_tready);
  assign last_byte = (byte_idx == head_job.nbytes - 3'd1);
  assign pop       = load && last_byte;

  // Byte index within the head job.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_idx <= '0;
    end else if (load) begin
      byte_idx <= last_byte ? 3'd0 : byte_idx + 3'd1;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata    <= byte_sel;
      m_tlast    <= last_byte;
      m_tuser[0] <= head_job.err;
    end
  end

endmodule

// ----- design/base32_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// Base32 stream decoder
// Decodes base32 text, one character per beat, into a stream of bytes.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one ASCII character per beat in s_tdata, with
//   s_tlast marking the final character of a stream. The master channel
//   gives one decoded byte per beat; m_tlast marks the last byte caused by
//   one input beat and m_tuser flags an invalid character (data then zero).
//   A character is taken every cycle while the job queue has room, so the
//   block sustains one character per cycle. The front end closes a group on
//   its eighth symbol or on s_tlast, and an error at once; each closed group
//   becomes a job of one to five bytes in a four-entry queue. The emitter
//   sends one byte per cycle while the receiver takes them; the first byte of
//   a job is written into the queue and then loaded into the output register.
//   When the receiver stalls, the output register holds its byte, the queue
//   fills, and s_tready falls once all four entries are taken. Reset clears
//   the open group, the error discard state, the queue and the output valid
//   flag; no byte is pending.
// ----------------------------------------------------------------------------
module base32_stream_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] symbol
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] data_byte
  output logic       m_tlast,
  output logic [0:0] m_tuser    // [0] is_error
);

  logic           accept;
  logic           push;
  logic           full;
  logic           pop;
  logic           head_valid;
  b32d_pkg::job_t push_job;
  b32d_pkg::job_t head_job;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  b32d_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .symbol        (s_tdata),
    .end_of_stream (s_tlast),
    .push          (push),
    .job           (push_job)
  );

  b32d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  b32d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// Base32 stream decoder testbench
// Streams base32 characters into the decoder and checks every output beat
// against a cycle-free model of the decoder that runs in the bench.
// A short directed part covers full groups, padding, short final groups and
// invalid characters. Random streams follow under three idle settings.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any accepted beat before the run is abandoned.
  localparam int unsigned STALL_LIMIT = 5000;
  // Quiet cycles allowed at the end, once no byte is outstanding.
  localparam int unsigned TAIL_CYCLES = 20;
  // Bytes given by a group, indexed by first pad position or short count.
  localparam logic [2:0] BYTES_FOR_INDEX [8] = '{3'd5, 3'd1, 3'd1, 3'd2,
                                                 3'd2, 3'd3, 3'd4, 3'd4};

  // One decoded byte as it should appear on the master side.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_error;
    logic       run_last;
  } byte_result_t;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = '0;    // [7:0] symbol
  logic       s_tlast  = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;          // [7:0] data_byte
  logic       m_tlast;
  logic [0:0] m_tuser;          // [0] is_error

  // Idle rates in percent, changed between phases.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned fail_count    = 0;
  int unsigned quiet_cycles  = 0;

  // Bytes predicted but not yet seen on the master side.
  byte_result_t pending_bytes [$];

  // Model state of the decoder.
  logic [4:0] grp_sym [8];
  logic [2:0] grp_cnt;
  logic [2:0] pad_pos;
  logic       drop_mode;

  base32_stream_decoder uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure, changed on the falling edge.
  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= recv_idle_pct);
  end

  // Check each accepted output beat against the oldest predicted byte.
  always @(posedge clk) begin
    byte_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected beat: data_byte %02h is_error %0b run_last %0b",
               m_tdata, m_tuser[0], m_tlast);
        fail_count++;
      end else begin
        want = pending_bytes.pop_front();
        if (m_tdata !== want.data_byte) begin
          $error("data_byte: expected %02h, actual %02h", want.data_byte, m_tdata);
          fail_count++;
        end
        if (m_tuser[0] !== want.is_error) begin
          $error("is_error: expected %0b, actual %0b", want.is_error, m_tuser[0]);
          fail_count++;
        end
        if (m_tlast !== want.run_last) begin
          $error("run_last: expected %0b, actual %0b", want.run_last, m_tlast);
          fail_count++;
        end
      end
    end
  end

  // Abandon the run when nothing moves on either side for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Class and value of one character.
  function automatic b32d_pkg::sym_t symbol_class(input logic [7:0] c);
    b32d_pkg::sym_t s;
    s.kind  = b32d_pkg::SYM_DATA;
    s.value = '0;
    if (c >= b32d_pkg::CHAR_LOWER_A && c <= b32d_pkg::CHAR_LOWER_Z) begin
      s.value = 5'(c - b32d_pkg::CHAR_LOWER_A);
    end else if (c >= b32d_pkg::CHAR_UPPER_A && c <= b32d_pkg::CHAR_UPPER_Z) begin
      s.value = 5'(c - b32d_pkg::CHAR_UPPER_A);
    end else if (c >= b32d_pkg::CHAR_TWO && c <= b32d_pkg::CHAR_SEVEN) begin
      s.value = 5'(c - b32d_pkg::CHAR_TWO + 8'd26);
    end else if (c == b32d_pkg::CHAR_ONE) begin
      s.value = b32d_pkg::VALUE_OF_ONE;
    end else if (c == b32d_pkg::CHAR_PAD) begin
      s.kind = b32d_pkg::SYM_PAD;
    end else begin
      s.kind = b32d_pkg::SYM_BAD;
    end
    return s;
  endfunction

  function automatic void clear_group();
    foreach (grp_sym[i]) grp_sym[i] = '0;
    grp_cnt = '0;
    pad_pos = '0;
  endfunction

  // Queue the first nbytes bytes of the open group, the last one marked.
  function automatic void push_group_bytes(input logic [2:0] nbytes);
    logic [39:0]  bits;
    byte_result_t r;
    bits = {grp_sym[0], grp_sym[1], grp_sym[2], grp_sym[3],
            grp_sym[4], grp_sym[5], grp_sym[6], grp_sym[7]};
    for (int k = 0; k < nbytes; k++) begin
      r.data_byte = bits[39 - 8 * k -: 8];
      r.is_error  = 1'b0;
      r.run_last  = (k == nbytes - 1);
      pending_bytes.push_back(r);
    end
  endfunction

  // Advance the model by one accepted character and queue its bytes.
  function automatic void decode_symbol(input logic [7:0] c, input logic eos);
    b32d_pkg::sym_t s;
    byte_result_t   r;
    if (drop_mode) begin
      if (eos) drop_mode = 1'b0;
      return;
    end
    s = symbol_class(c);
    if (s.kind == b32d_pkg::SYM_BAD) begin
      r.data_byte = '0;
      r.is_error  = 1'b1;
      r.run_last  = 1'b1;
      pending_bytes.push_back(r);
      clear_group();
      drop_mode = !eos;
      return;
    end
    if (s.kind == b32d_pkg::SYM_PAD) begin
      grp_sym[grp_cnt] = '0;
      // Only the first pad after index 0 is recorded.
      if (pad_pos == 0) pad_pos = grp_cnt;
    end else begin
      grp_sym[grp_cnt] = s.value;
    end
    if (grp_cnt == 3'd7) begin
      push_group_bytes(BYTES_FOR_INDEX[pad_pos]);
      clear_group();
    end else begin
      grp_cnt++;
      // A short final group gives bytes by its symbol count.
      if (eos) begin
        push_group_bytes(BYTES_FOR_INDEX[grp_cnt]);
        clear_group();
      end
    end
    if (eos) begin
      clear_group();
      drop_mode = 1'b0;
    end
  endfunction

  // Send one character, with random idle cycles ahead of it.
  task automatic send_symbol(input logic [7:0] c, input logic eos);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = c;
    s_tlast  = eos;
    do @(posedge clk); while (!s_tready);
    decode_symbol(c, eos);
  endtask

  task automatic send_text(input string txt, input logic eos_on_last);
    for (int i = 0; i < txt.len(); i++) begin
      send_symbol(txt[i], eos_on_last && (i == txt.len() - 1));
    end
  endtask

  // Stop sending and wait until every predicted byte has come out.
  task automatic wait_drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  // Mostly valid alphabet characters, some pads and some arbitrary bytes.
  function automatic logic [7:0] random_symbol();
    int unsigned roll;
    int unsigned idx;
    roll = $urandom_range(99);
    if (roll < 3) return b32d_pkg::CHAR_PAD;
    if (roll < 10) return 8'($urandom_range(255));
    if (roll < 13) return b32d_pkg::CHAR_ONE;
    idx = $urandom_range(31);
    if (idx >= 26) return 8'(b32d_pkg::CHAR_TWO + idx - 26);
    return ($urandom_range(1) != 0) ? 8'(b32d_pkg::CHAR_LOWER_A + idx) :
                                      8'(b32d_pkg::CHAR_UPPER_A + idx);
  endfunction

  // A full group with mixed case, both digit ends and '1'.
  task automatic test_full_group();
    send_text("Az1m7b2Q", 1'b0);
  endtask

  // A pad at index 0 is not recorded; the one at index 4 gives two bytes.
  task automatic test_padding();
    send_text("=MZX=Y==", 1'b0);
  endtask

  // A three-symbol final group gives two bytes.
  task automatic test_short_group();
    send_text("MZX", 1'b1);
  endtask

  // Invalid characters, the discard that follows, and an error on a final
  // character.
  task automatic test_invalid();
    send_symbol(b32d_pkg::CHAR_UPPER_A + 8'd12, 1'b0);
    send_symbol(8'hff, 1'b0);
    send_symbol(b32d_pkg::CHAR_UPPER_A, 1'b0);
    send_symbol(b32d_pkg::CHAR_UPPER_A + 8'd1, 1'b1);
    send_symbol(8'h00, 1'b1);
    // A lone pad as a whole stream gives one zero byte.
    send_symbol(b32d_pkg::CHAR_PAD, 1'b1);
    wait_drain();
  endtask

  // Random streams, partly with standard tail padding, until n_items are sent.
  task automatic test_random_streams(input int n_items);
    int         sent;
    int         len;
    int         npad;
    logic [7:0] c;
    sent = 0;
    while (sent < n_items) begin
      len  = ($urandom_range(3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 16);
      npad = 0;
      if ($urandom_range(3) == 0) begin
        len = ((len + 7) / 8) * 8;
        case ($urandom_range(4))
          0:       npad = 0;
          1:       npad = 1;
          2:       npad = 3;
          3:       npad = 4;
          default: npad = 6;
        endcase
      end
      for (int i = 0; i < len; i++) begin
        c = (i >= len - npad) ? b32d_pkg::CHAR_PAD : random_symbol();
        send_symbol(c, i == len - 1);
      end
      sent += len;
      // Now and then let the output side empty completely.
      if ($urandom_range(7) == 0) wait_drain();
    end
    wait_drain();
  endtask

  initial begin
    clear_group();
    drop_mode = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Sender idles a fifth of the time, receiver most of the time.
    send_idle_pct = 20;
    recv_idle_pct = 73;
    test_full_group();
    test_padding();
    test_short_group();
    test_invalid();
    test_random_streams(150);

    // The other way round.
    send_idle_pct = 73;
    recv_idle_pct = 20;
    test_random_streams(150);

    // Neither side idles.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_streams(150);

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_bytes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
